### design/bfks_pkg.sv
// ----------------------------------------------------------------------------
// bfks_pkg
// Shared types and constants for the bounded queue with id search.
// ----------------------------------------------------------------------------
package bfks_pkg;

    localparam int OP_W  = 3;
    localparam int ID_W  = 16;
    localparam int TAG_W = 8;
    localparam int MEM_W = 10;
    localparam int CNT_W = 5;   // capacity register, count and occupancy

    typedef enum logic [OP_W-1:0] {
        OP_ENQ    = 3'd0,
        OP_DEQ    = 3'd1,
        OP_PEEK_H = 3'd2,
        OP_PEEK_T = 3'd3,
        OP_SRCH   = 3'd4,
        OP_CLR    = 3'd5
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
        logic [MEM_W-1:0] mem;
    } rec_t;

    typedef enum logic [1:0] {
        RD_FRONT     = 2'd0,
        RD_TAIL      = 2'd1,
        RD_SCAN_NEXT = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        UPD_NONE = 2'd0,
        UPD_ENQ  = 2'd1,
        UPD_DEQ  = 2'd2,
        UPD_CLR  = 2'd3
    } upd_t;

    typedef struct packed {
        logic    req_ready;
        logic    wr_en;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    scan_init;
        logic    scan_step;
        upd_t    upd;
        logic    out_load;
        logic    res_ok;
        logic    res_rec;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            req_valid;
        logic            count_zero;
        logic            can_enq;
        logic            out_free;
        logic            scan_hit;
        logic            scan_last;
    } stat_t;

endpackage

### design/bfks_req_if.sv
// ----------------------------------------------------------------------------
// bfks_req_if
// Request channel: one queue operation with its record fields.
// ----------------------------------------------------------------------------
interface bfks_req_if;
    import bfks_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [ID_W-1:0]  proc_id;
    logic [TAG_W-1:0] name_tag;
    logic [MEM_W-1:0] mem_tenths;

    modport source (output valid, operation, proc_id, name_tag, mem_tenths, input ready);
    modport sink   (input valid, operation, proc_id, name_tag, mem_tenths, output ready);
endinterface

### design/bfks_rsp_if.sv
// ----------------------------------------------------------------------------
// bfks_rsp_if
// Result channel: status flag, record and queue fill state.
// ----------------------------------------------------------------------------
interface bfks_rsp_if;
    import bfks_pkg::*;

    logic             valid;
    logic             ready;
    logic             ok;
    logic [ID_W-1:0]  out_id;
    logic [TAG_W-1:0] out_tag;
    logic [MEM_W-1:0] out_mem;
    logic [CNT_W-1:0] occupancy;
    logic             is_empty;
    logic             is_full;

    modport source (output valid, ok, out_id, out_tag, out_mem, occupancy, is_empty, is_full,
                    input ready);
    modport sink   (input valid, ok, out_id, out_tag, out_mem, occupancy, is_empty, is_full,
                    output ready);
endinterface

### design/bfks_ctrl.sv
// ----------------------------------------------------------------------------
// bfks_ctrl
// Sequencer: decodes the latched operation and steps the datapath.
// ----------------------------------------------------------------------------
module bfks_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  bfks_pkg::stat_t stat,
    output bfks_pkg::cmd_t  cmd
);
    import bfks_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_SCAN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.rd_sel    = RD_FRONT;
        cmd.upd       = UPD_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.req_ready = 1'b1;
                if (stat.req_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    unique case (stat.op)
                        OP_ENQ:
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = S_IDLE;
                            if (stat.can_enq)
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.upd    = UPD_ENQ;
                                cmd.res_ok = 1'b1;
                            end
                        end
                        OP_DEQ, OP_PEEK_H, OP_PEEK_T:
                        begin
                            if (stat.count_zero)
                            begin
                                cmd.out_load = 1'b1;
                                state_next   = S_IDLE;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = (stat.op == OP_PEEK_T) ? RD_TAIL : RD_FRONT;
                                state_next = S_READ;
                            end
                        end
                        OP_SRCH:
                        begin
                            if (stat.count_zero)
                            begin
                                cmd.out_load = 1'b1;
                                state_next   = S_IDLE;
                            end
                            else
                            begin
                                cmd.rd_en     = 1'b1;
                                cmd.rd_sel    = RD_FRONT;
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        OP_CLR:
                        begin
                            cmd.upd      = UPD_CLR;
                            cmd.res_ok   = 1'b1;
                            cmd.out_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                        default:
                        begin
                            // unused codes: refused, nothing changes
                            cmd.out_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res_ok   = 1'b1;
                    cmd.res_rec  = 1'b1;
                    cmd.upd      = (stat.op == OP_DEQ) ? UPD_DEQ : UPD_NONE;
                    state_next   = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (stat.scan_hit || stat.scan_last)
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.res_ok   = stat.scan_hit;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = RD_SCAN_NEXT;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### design/bfks_dp.sv
// ----------------------------------------------------------------------------
// bfks_dp
// Datapath: ring buffer memory, pointers, count, scan cursor, result register.
// ----------------------------------------------------------------------------
module bfks_dp #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bfks_pkg::CNT_W-1:0] cfg_wdata,
    bfks_req_if.sink                  req,
    bfks_rsp_if.source                rsp,
    input  bfks_pkg::cmd_t            cmd,
    output bfks_pkg::stat_t           stat
);
    import bfks_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    rec_t             mem_arr [DEPTH];
    rec_t             rd_data_reg;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_eff;

    logic [OP_W-1:0]  op_reg;
    rec_t             in_rec_reg;

    logic [IDX_W-1:0] scan_idx_reg;
    logic [CNT_W-1:0] scan_left_reg;

    logic [IDX_W-1:0] rd_addr;
    logic             out_valid_reg;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : IDX_W'(i - 1'b1);
    endfunction

    // effective capacity: register clamped into 1..DEPTH
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(16);
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg         <= req.operation;
            in_rec_reg.id  <= req.proc_id;
            in_rec_reg.tag <= req.name_tag;
            in_rec_reg.mem <= req.mem_tenths;
        end
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FRONT:     rd_addr = front_reg;
            RD_TAIL:      rd_addr = idx_dec(back_reg);
            RD_SCAN_NEXT: rd_addr = idx_inc(scan_idx_reg);
            default:      rd_addr = front_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_arr[back_reg] <= in_rec_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem_arr[rd_addr];
        end
    end

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        unique case (cmd.upd)
            UPD_ENQ:
            begin
                back_next  = idx_inc(back_reg);
                count_next = CNT_W'(count_reg + 1'b1);
            end
            UPD_DEQ:
            begin
                front_next = idx_inc(front_reg);
                count_next = CNT_W'(count_reg - 1'b1);
            end
            UPD_CLR:
            begin
                front_next = '0;
                back_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // search cursor
    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            scan_idx_reg  <= front_reg;
            scan_left_reg <= count_reg;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg  <= idx_inc(scan_idx_reg);
            scan_left_reg <= CNT_W'(scan_left_reg - 1'b1);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp.ok        <= cmd.res_ok;
            rsp.out_id    <= cmd.res_rec ? rd_data_reg.id  : '0;
            rsp.out_tag   <= cmd.res_rec ? rd_data_reg.tag : '0;
            rsp.out_mem   <= cmd.res_rec ? rd_data_reg.mem : '0;
            rsp.occupancy <= count_next;
            rsp.is_empty  <= (count_next == '0);
            rsp.is_full   <= (count_next >= cap_eff);
        end
    end

    assign rsp.valid = out_valid_reg;
    assign req.ready = cmd.req_ready;

    assign stat.op         = op_reg;
    assign stat.req_valid  = req.valid;
    assign stat.count_zero = (count_reg == '0);
    assign stat.can_enq    = (count_reg < cap_eff);
    assign stat.out_free   = !out_valid_reg || rsp.ready;
    assign stat.scan_hit   = (rd_data_reg.id == in_rec_reg.id);
    assign stat.scan_last  = (scan_left_reg == CNT_W'(1));

endmodule

### design/bounded_fifo_with_key_search.sv
// ----------------------------------------------------------------------------
// bounded_fifo_with_key_search
// Bounded queue of process records with dequeue, peek and search by id.
// ----------------------------------------------------------------------------
// steps: enqueue, clear and refused operations latch the request, then load the result;
//   dequeue and peek add one registered memory read first; search reads the records
//   one at a time, one memory read per record, until the id matches or none is left
// throughput: one request at a time, next request taken the cycle after the result loads
// reset: queue empty, capacity 16, memory contents left as they are
module bounded_fifo_with_key_search #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bfks_pkg::CNT_W-1:0] cfg_wdata,
    bfks_req_if.sink                  req,
    bfks_rsp_if.source                rsp
);
    import bfks_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bfks_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    bfks_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
